[rtl/rvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_pkg - shared types and constants of the register value scaler
// Mode, status and rounding unit codes, sequencer states, value limits.
// ----------------------------------------------------------------------------
package rvs_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 256;

  // value width in thousandths and its signed limits
  localparam int unsigned VAL_W = 48;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // dividend width: 2*|num| + rounded divisor, |num| < 2^47
  localparam int unsigned NUM_W    = 49;
  // divisor width: 2 * |arg| * 100 < 2^40
  localparam int unsigned DEN_W    = 40;
  // width of a value after the unit multiply
  localparam int unsigned WIDE_W   = 56;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  localparam logic [31:0] SCALE_NONE = 32'd1000;
  localparam logic [31:0] SCALE_DIV  = 32'd1000000;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_DZ  = 2'd1,
    STAT_SAT = 2'd2,
    STAT_RSV = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    UNIT_1   = 2'd0,
    UNIT_10  = 2'd1,
    UNIT_100 = 2'd2,
    UNIT_RSV = 2'd3
  } unit_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } state_t;

  // x * unit by shift and add
  function automatic logic [WIDE_W-1:0] times_unit(input logic [WIDE_W-1:0] x,
                                                   input unit_t u);
    logic [WIDE_W-1:0] r;
    case (u)
      UNIT_10:  r = (x << 3) + (x << 1);
      UNIT_100: r = (x << 6) + (x << 5) + (x << 2);
      default:  r = x;
    endcase
    return r;
  endfunction

endpackage

[rtl/register_value_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_value_scaler - scale a raw register word to thousandths
// Byte swap, sign, multiply/divide, round half away from zero, compare with
// the per-slot stored value and report a changed flag.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                                  | item
//  --------+-----+----------------------------------------+------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata/in_tuser  | one raw word + attributes
//  out     | out | out_tvalid/out_tready/out_tdata        | one scaled value
//  cfg     | in  | cfg_wr_en/cfg_wr_data                  | swap_bytes register
//
//  Each item goes from accept to result valid through one multiply, one
//  divisor prep, 49 steps of the restoring divider, one scale/store read and
//  one output load. The 49-step divider sets the rate; in_tready is low
//  meanwhile. After reset a clearing pass zeroes the value store, with
//  in_tready low. A stalled output holds the finished item; the next item can
//  be accepted and works up to its output load meanwhile.
//
module register_value_scaler
  import rvs_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // swap_bytes

  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] slot_index, [23:8] raw_word, [25:24] mode, [57:26] scale_argument,
  // [61:58] decimals, [63:62] zero
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,      // [0] is_signed

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] slot_out, [55:8] scaled_value, [56] changed, [58:57] status,
  // [63:59] zero
  output logic [63:0] out_tdata
);

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // input field views
  logic [7:0]  in_slot;
  logic [15:0] in_raw;
  mode_t       in_mode;
  logic [31:0] in_arg;
  logic [3:0]  in_dec;
  logic [15:0] word;

  assign in_slot = in_tdata[7:0];
  assign in_raw  = in_tdata[23:8];
  assign in_mode = mode_t'(in_tdata[25:24]);
  assign in_arg  = in_tdata[57:26];
  assign in_dec  = in_tdata[61:58];

  // control
  state_t             state_r, state_nxt;
  logic               swap_r;
  logic [SLOT_W-1:0]  clr_cnt_r;
  logic [CNT_W-1:0]   cnt_r;

  // per-item operands
  logic [7:0]         slot_r;
  logic               vneg_r;
  logic [15:0]        vmag_r;
  logic [31:0]        amag_r;
  mode_t              mode_r;
  unit_t              unit_r;
  logic               neg_r;
  logic               dz_r;

  // datapath
  logic [VAL_W-1:0]   mag_r;
  logic [NUM_W-1:0]   n_r;      // dividend, then quotient
  logic [DEN_W-1:0]   rem_r;
  logic [DEN_W-1:0]   div_r;
  logic [VAL_W-1:0]   res_r;
  status_t            stat_r;
  logic [VAL_W-1:0]   rd_r;

  // output register
  logic               out_valid_r;
  logic [7:0]         out_slot_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_changed_r;
  status_t            out_status_r;

  // value store
  logic [VAL_W-1:0]   store_mem [SLOT_COUNT];

  logic               accept;
  logic               load_out;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  slot_mod_tab [256];   // slot modulo SLOT_COUNT, constant

  // shared arithmetic
  logic [31:0]        mul_b;
  logic [VAL_W-1:0]   prod;
  logic [WIDE_W-1:0]  tu_in;
  logic [WIDE_W-1:0]  tu_out;
  logic [31:0]        dmag;
  logic [DEN_W-1:0]   rem_sh;
  logic               ge;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign word     = swap_r ? {in_raw[7:0], in_raw[15:8]} : in_raw;

  for (genvar g = 0; g < 256; g++) begin : g_slot_mod
    assign slot_mod_tab[g] = SLOT_W'(g % SLOT_COUNT);
  end

  assign idx = slot_mod_tab[slot_r];

  // operand multiplier: |v| times |arg|, 1000 or 1000000
  always_comb begin
    case (mode_r)
      MODE_MUL: mul_b = amag_r;
      MODE_DIV: mul_b = SCALE_DIV;
      default:  mul_b = SCALE_NONE;
    endcase
  end
  assign prod = VAL_W'(vmag_r) * VAL_W'(mul_b);

  // unit shift-add, shared by divisor prep and final scale
  assign dmag  = (mode_r == MODE_DIV) ? amag_r : 32'd1;
  assign tu_in = (state_r == ST_PREP) ? WIDE_W'(dmag) : WIDE_W'(n_r);
  assign tu_out = times_unit(tu_in, unit_r);

  // restoring divider step
  assign rem_sh = {rem_r[DEN_W-2:0], n_r[NUM_W-1]};
  assign ge     = (rem_sh >= div_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == SLOT_W'(SLOT_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      swap_r      <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) swap_r <= cfg_wr_data;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_r <= in_slot;
          vneg_r <= in_tuser && word[15];
          vmag_r <= (in_tuser && word[15]) ? (16'd0 - word) : word;
          amag_r <= in_arg[31] ? (32'd0 - in_arg) : in_arg;
          mode_r <= in_mode;
          neg_r  <= (in_mode == MODE_MUL || in_mode == MODE_DIV) ?
                    ((in_tuser && word[15]) ^ in_arg[31]) : (in_tuser && word[15]);
          dz_r   <= (in_mode == MODE_DIV) && (in_arg == 32'd0);
          case (in_dec)
            4'd1:    unit_r <= UNIT_100;
            4'd2:    unit_r <= UNIT_10;
            default: unit_r <= UNIT_1;
          endcase
        end
      end
      ST_MUL: begin
        mag_r <= prod;
      end
      ST_PREP: begin
        // round half away: (2*num + den) / (2*den)
        n_r   <= {mag_r, 1'b0} + NUM_W'(tu_out);
        div_r <= {tu_out[DEN_W-2:0], 1'b0};
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= ge ? (rem_sh - div_r) : rem_sh;
        n_r   <= {n_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_SCALE: begin
        if (dz_r) begin
          stat_r <= STAT_DZ;
          res_r  <= (vmag_r == 16'd0) ? '0 : (vneg_r ? VAL_MIN : VAL_MAX);
        end else if (!neg_r && tu_out > WIDE_W'(VAL_MAX)) begin
          stat_r <= STAT_SAT;
          res_r  <= VAL_MAX;
        end else if (neg_r && tu_out > WIDE_W'(VAL_MAX) + 1'b1) begin
          stat_r <= STAT_SAT;
          res_r  <= VAL_MIN;
        end else begin
          stat_r <= STAT_OK;
          res_r  <= neg_r ? (VAL_W'(0) - tu_out[VAL_W-1:0]) : tu_out[VAL_W-1:0];
        end
        rd_r <= store_mem[idx];
      end
      default: begin
      end
    endcase
  end

  // value store write: clearing pass or result update
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) store_mem[clr_cnt_r] <= '0;
    else if (load_out) store_mem[idx] <= res_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_slot_r    <= slot_r;
      out_value_r   <= res_r;
      out_changed_r <= (res_r != rd_r);
      out_status_r  <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_changed_r, out_value_r, out_slot_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken again while an item is in work");

  a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status_r == STAT_DZ) |->
      (out_value_r == VAL_MAX || out_value_r == VAL_MIN || out_value_r == '0))
    else $error("divide by zero result not a limit or zero");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status_r == STAT_SAT) |->
      (out_value_r == VAL_MAX || out_value_r == VAL_MIN))
    else $error("saturated result not at a limit");

  a_load_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> $past(state_r == ST_SCALE) || $past(state_r == ST_OUT))
    else $error("output loaded without a finished scale step");

endmodule

[tb/register_value_scaler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_value_scaler_test - self-checking bench for the register scaler
// Streams raw register words through the scaler and checks every result
// against a local predictor with its own value store. It covers both byte
// orders, all modes, rounding, divide by zero, repeated values and back
// pressure.
// ----------------------------------------------------------------------------
module register_value_scaler_test;
  import rvs_pkg::*;

  localparam int unsigned SLOTS          = 256;
  localparam int          ITEM_LATENCY   = 53;    // accept to out_tvalid
  localparam int          WATCHDOG_LIMIT = 3000;  // cycles with no handshake
  localparam int          HOLD_CYCLES    = 400;   // long receiver hold-off

  // signed limits of the 48-bit value, in thousandths
  localparam longint VALUE_HI = 64'sd140737488355327;
  localparam longint VALUE_LO = -VALUE_HI - 1;

  // one raw word with its attributes
  typedef struct packed {
    logic [7:0]  slot;
    logic [15:0] raw;
    logic        is_signed;
    mode_t       mode;
    logic [31:0] arg;       // signed, thousandths
    logic [3:0]  decimals;
  } word_item_t;

  // one scaled result
  typedef struct packed {
    logic [7:0]  slot;
    logic [47:0] value;
    logic        changed;
    status_t     status;
  } scaled_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  word_item_t     pending_words[$];   // waiting to be offered
  word_item_t     corner_words[$];    // directed list, replayed per byte order
  scaled_result_t results_due[$];     // predicted, not yet seen
  word_item_t     offered;            // item currently on the input bus
  logic [47:0]    slot_store [SLOTS]; // predictor copy of the value store
  bit             swap_model = 1'b0;

  bit quiet = 1'b0;          // last part of the run: no idling at all
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_req = 0;          // bumped by the sequence to start a long hold
  int hold_ack = 0;
  int idle_cycles = 0;

  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int dz_seen = 0;
  int unchanged_seen = 0;
  int swap_writes = 0;

  register_value_scaler #(
    .SLOT_COUNT(SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Predict one result. Single rounding of the exact quotient, half away
  // from zero, to a multiple of the decimal unit.
  function automatic scaled_result_t scale_word(input word_item_t it, input bit swap,
                                                input logic [47:0] prior);
    scaled_result_t    r;
    logic [15:0]       w;
    longint            v, a, num, den, val;
    longint unsigned   unit, mag, dmag, q;
    bit                neg;
    w = swap ? {it.raw[7:0], it.raw[15:8]} : it.raw;
    v = {48'd0, w};
    if (it.is_signed && w[15]) v = v - 65536;
    a = longint'($signed(it.arg));
    case (it.decimals)
      4'd1:    unit = 100;
      4'd2:    unit = 10;
      default: unit = 1;     // 3 decimals is full thousandths; 0, 4+ no rounding
    endcase
    case (it.mode)
      MODE_MUL: begin
        num = v * a;
        den = 1;
      end
      MODE_DIV: begin
        num = v * 1000000;
        den = a;
      end
      default: begin         // none and the spare code both pass through
        num = v * 1000;
        den = 1;
      end
    endcase
    if (den == 0) begin
      // divide by zero: saturate toward the sign of the word, no rounding
      r.status = STAT_DZ;
      val = (v > 0) ? VALUE_HI : ((v < 0) ? VALUE_LO : 64'sd0);
    end else begin
      r.status = STAT_OK;
      neg  = (num < 0) != (den < 0);
      mag  = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      q = ((2 * mag + dmag * unit) / (2 * dmag * unit)) * unit;
      if (!neg && q > VALUE_HI) begin
        r.status = STAT_SAT;
        val = VALUE_HI;
      end else if (neg && q > VALUE_HI + 1) begin
        r.status = STAT_SAT;
        val = VALUE_LO;
      end else begin
        val = neg ? -longint'(q) : longint'(q);
      end
    end
    r.slot    = it.slot;
    r.value   = val[47:0];
    r.changed = (val[47:0] != prior);
    return r;
  endfunction

  function automatic word_item_t make_word(input logic [7:0] slot, input logic [15:0] raw,
                                           input logic sgn, input mode_t mode,
                                           input logic [31:0] arg, input logic [3:0] dec);
    word_item_t it;
    it.slot      = slot;
    it.raw       = raw;
    it.is_signed = sgn;
    it.mode      = mode;
    it.arg       = arg;
    it.decimals  = dec;
    return it;
  endfunction

  // Random word: few slots for many repeats, biased raw and argument values
  function automatic word_item_t random_word();
    word_item_t it;
    int         small_arg;
    it.slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    case ($urandom_range(0, 7))
      0:       it.raw = 16'h0000;
      1:       it.raw = 16'hFFFF;
      2:       it.raw = 16'h8000;
      3:       it.raw = 16'h7FFF;
      4, 5:    it.raw = 16'($urandom_range(0, 15));
      default: it.raw = 16'($urandom);
    endcase
    it.is_signed = 1'($urandom_range(0, 1));
    it.mode      = mode_t'(2'($urandom_range(0, 3)));
    small_arg    = $urandom_range(0, 4000);
    if ($urandom_range(0, 1)) small_arg = -small_arg;
    case ($urandom_range(0, 9))
      0:       it.arg = 32'h0000_0000;
      1:       it.arg = 32'h7FFF_FFFF;
      2:       it.arg = 32'h8000_0000;
      3, 4:    it.arg = small_arg;
      5:       it.arg = 32'd1000;
      default: it.arg = $urandom;
    endcase
    it.decimals = $urandom_range(0, 1) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
    return it;
  endfunction

  // Input driver: one NBA per signal per edge, random gaps between items
  always @(posedge clk) begin : drive_proc
    word_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        nxt = pending_words.pop_front();
        offered   <= nxt;
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, nxt.decimals, nxt.arg, nxt.mode, nxt.raw, nxt.slot};
        in_tuser  <= nxt.is_signed;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold when the sequence asks
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack   = hold_req;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Predict at input accept; the store update follows the item order
  always @(posedge clk) begin : predict_proc
    scaled_result_t r;
    if (!rst_n) begin
      foreach (slot_store[i]) slot_store[i] = '0;
    end else if (in_tvalid && in_tready) begin
      r = scale_word(offered, swap_model, slot_store[offered.slot]);
      slot_store[offered.slot] = r.value;
      results_due = {results_due, r};
      accepted++;
      if (r.status == STAT_DZ) dz_seen++;
      if (!r.changed) unchanged_seen++;
    end
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin : check_proc
    scaled_result_t want;
    logic [47:0]    got_value;
    status_t        got_status;
    if (rst_n && out_tvalid && out_tready) begin
      got_value  = out_tdata[55:8];
      got_status = status_t'(out_tdata[58:57]);
      if (results_due.size() == 0) begin
        $error("unexpected result item: slot_out %0d", out_tdata[7:0]);
        errors++;
      end else begin
        want = results_due.pop_front();
        checked++;
        if (out_tdata[7:0] != want.slot) begin
          $error("slot_out: expected %0d, got %0d", want.slot, out_tdata[7:0]);
          errors++;
        end
        if (got_value != want.value) begin
          $error("scaled_value: expected %0d, got %0d",
                 $signed(want.value), $signed(got_value));
          errors++;
        end
        if (out_tdata[56] != want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, out_tdata[56]);
          errors++;
        end
        if (got_status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, results_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Wait at negedges (after all edge updates) until nothing is in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || results_due.size() != 0);
  endtask

  // swap_bytes is written only with the scaler idle
  task automatic write_swap(input bit val);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    swap_model  = val;
    swap_writes++;
  endtask

  task automatic add_corner(input word_item_t it);
    corner_words = {corner_words, it};
  endtask

  task automatic queue_random(input int count);
    word_item_t prev;
    prev = random_word();
    for (int i = 0; i < count; i++) begin
      // now and then repeat the last word so the unchanged flag shows up
      if ($urandom_range(0, 9) != 0) prev = random_word();
      pending_words = {pending_words, prev};
    end
  endtask

  initial begin
    // directed corners: extremes, every mode, rounding halves, divide by zero
    add_corner(make_word(8'd0,   16'h0000, 1'b0, MODE_NONE, 32'd0,        4'd0));
    add_corner(make_word(8'd255, 16'hFFFF, 1'b0, MODE_NONE, 32'd0,        4'd0));
    add_corner(make_word(8'd1,   16'hFFFF, 1'b1, MODE_NONE, 32'd5,        4'd3));
    add_corner(make_word(8'd2,   16'h8000, 1'b1, MODE_MUL,  32'h7FFFFFFF, 4'd0));
    add_corner(make_word(8'd3,   16'h7FFF, 1'b1, MODE_MUL,  32'h80000000, 4'd0));
    add_corner(make_word(8'd4,   16'hFFFF, 1'b0, MODE_MUL,  32'h80000000, 4'd1));
    add_corner(make_word(8'd5,   16'h0001, 1'b1, MODE_NOP,  32'd12345,    4'd2));
    add_corner(make_word(8'd6,   16'h0001, 1'b0, MODE_MUL,  32'd50,       4'd1));
    add_corner(make_word(8'd7,   16'hFFFF, 1'b1, MODE_MUL,  32'd50,       4'd1));
    add_corner(make_word(8'd8,   16'h0001, 1'b0, MODE_DIV,  32'd3000,     4'd0));
    add_corner(make_word(8'd9,   16'h0002, 1'b0, MODE_DIV,  32'd3000,     4'd3));
    add_corner(make_word(8'd10,  16'h0002, 1'b1, MODE_DIV,  -32'sd3000,   4'd2));
    add_corner(make_word(8'd11,  16'h0005, 1'b0, MODE_DIV,  32'd0,        4'd1));
    add_corner(make_word(8'd12,  16'hFFFB, 1'b1, MODE_DIV,  32'd0,        4'd2));
    add_corner(make_word(8'd13,  16'h0000, 1'b1, MODE_DIV,  32'd0,        4'd0));
    add_corner(make_word(8'd14,  16'h1234, 1'b0, MODE_DIV,  32'h80000000, 4'd4));
    add_corner(make_word(8'd15,  16'h1234, 1'b1, MODE_DIV,  32'h7FFFFFFF, 4'd15));
    // same words again for slots 11 and 255: store unchanged; then other words
    add_corner(make_word(8'd11,  16'h0005, 1'b0, MODE_DIV,  32'd0,        4'd1));
    add_corner(make_word(8'd255, 16'hFFFF, 1'b0, MODE_NONE, 32'd0,        4'd0));
    add_corner(make_word(8'h55,  16'h00FF, 1'b0, MODE_NONE, 32'd1,        4'd1));
    add_corner(make_word(8'hAA,  16'hFF00, 1'b1, MODE_MUL,  32'd1,        4'd3));
    add_corner(make_word(8'd16,  16'h0007, 1'b0, MODE_MUL,  -32'sd1,      4'd2));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // normal byte order, directed corners first
    write_swap(1'b0);
    pending_words = {pending_words, corner_words};

    // swapped bytes: corners again, then random words under a long hold
    write_swap(1'b1);
    pending_words = {pending_words, corner_words};
    queue_random(230);
    do @(negedge clk); while (pending_words.size() > 200);
    hold_req++;   // sender keeps offering, so the scaler backs up

    write_swap(1'b0);
    queue_random(250);

    write_swap(1'b1);
    queue_random(250);

    // last stretch: no idling on either side
    write_swap(1'b0);
    quiet = 1'b1;
    queue_random(270);

    wait_drained();
    repeat (2 * ITEM_LATENCY) @(posedge clk);

    $display("Ran %0d items through %0d swap_bytes writes, checked %0d results.",
             accepted, swap_writes, checked);
    $display("Seen %0d divide-by-zero results and %0d unchanged values.",
             dz_seen, unchanged_seen);
    if (errors == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rvs_pkg.sv
rtl/register_value_scaler.sv
tb/register_value_scaler_test.sv
